// ----- hdl/cpsms_pkg.sv -----
// Shared types and constants for the cascaded position/speed motion sequencer.
// No dependencies; the divider, the top level, the checker and the testbench import this package.
`default_nettype none
package cpsms_pkg;

  // phase codes as seen on the result channel
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_EXTEND    = 3'd1;
  localparam logic [2:0] PH_PAUSE_EXT = 3'd2;
  localparam logic [2:0] PH_RETRACT   = 3'd3;
  localparam logic [2:0] PH_PAUSE_RET = 3'd4;
  localparam logic [2:0] PH_COMPLETE  = 3'd5;
  localparam logic [2:0] PH_FAULT     = 3'd6;

  localparam logic [1:0] FLT_NONE    = 2'd0;
  localparam logic [1:0] FLT_EXTEND  = 2'd1;
  localparam logic [1:0] FLT_RETRACT = 2'd2;

  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_START_SEQ = 2'd1;
  localparam logic [1:0] CMD_START_MOV = 2'd2;
  localparam logic [1:0] CMD_STOP      = 2'd3;

  localparam logic [2:0] REG_OUTWARD_TARGET = 3'd0;
  localparam logic [2:0] REG_CYCLE_COUNT    = 3'd1;
  localparam logic [2:0] REG_PAUSE_MS       = 3'd2;
  localparam logic [2:0] REG_TIMEOUT_MS     = 3'd3;
  localparam logic [2:0] REG_SEQ_LIMIT      = 3'd4;
  localparam logic [2:0] REG_POSITION_GAIN  = 3'd5;
  localparam logic [2:0] REG_FF_GAIN        = 3'd6;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd7;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // duty clamp in percent x100, and start-sequence provisional drive
  localparam int DUTY_MIN_X100 = 1000;
  localparam int DUTY_MAX_X100 = 9500;
  localparam logic signed [7:0] DUTY_START = 8'sd95;

  // floor(m * 5243 / 2^19) == floor(m / 100) for m <= 9500
  localparam int RECIP100_MUL   = 5243;
  localparam int RECIP100_SHIFT = 19;

  typedef struct packed {
    logic load;
    logic step;
  } sdiv_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/cpsms_item_if.sv -----
// Input channel of the motion sequencer: valid/ready plus the command item.
// Depends on nothing.
`default_nettype none
interface cpsms_item_if #(
  parameter int PW = 24,
  parameter int TW = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [TW-1:0]        now_ms;
  logic signed [PW-1:0] position;
  logic signed [15:0]   measured_speed;
  logic signed [PW-1:0] move_target;
  logic signed [15:0]   move_speed_limit;

  modport source (output valid, cmd, now_ms, position, measured_speed, move_target,
                  move_speed_limit, input ready);
  modport sink (input valid, cmd, now_ms, position, measured_speed, move_target,
                move_speed_limit, output ready);
endinterface
`default_nettype wire

// ----- hdl/cpsms_result_if.sv -----
// Result channel of the motion sequencer: valid/ready plus the status item.
// Depends on nothing.
`default_nettype none
interface cpsms_result_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  duty;
  logic [2:0]         phase;
  logic [1:0]         fault_code;
  logic [7:0]         cycle_number;
  logic signed [15:0] position_error_diag;
  logic signed [15:0] speed_command_diag;
  logic signed [15:0] speed_error_diag;
  logic signed [15:0] integral_diag;

  modport source (output valid, duty, phase, fault_code, cycle_number, position_error_diag,
                  speed_command_diag, speed_error_diag, integral_diag, input ready);
  modport sink (input valid, duty, phase, fault_code, cycle_number, position_error_diag,
                speed_command_diag, speed_error_diag, integral_diag, output ready);
endinterface
`default_nettype wire

// ----- hdl/cpsms_sdiv.sv -----
// Bit-serial restoring divider by a constant: one quotient bit per step.
// Depends on cpsms_pkg (sdiv_ctl_t).
`default_nettype none
module cpsms_sdiv #(
  parameter int DW      = 16,
  parameter int DIVISOR = 10
) (
  input  logic                  clk,
  input  cpsms_pkg::sdiv_ctl_t  ctl,
  input  logic [DW-1:0]         dividend,
  output logic [DW-1:0]         quotient
);
  import cpsms_pkg::*;

  localparam int RW = $clog2(DIVISOR);

  logic [DW-1:0] num;
  logic [RW-1:0] rem;
  logic [RW:0]   r2;
  logic          ge;

  assign r2 = {rem, num[DW-1]};
  assign ge = (r2 >= (RW+1)'(DIVISOR));

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      num <= dividend;
      rem <= '0;
    end else if (ctl.step) begin
      num <= {num[DW-2:0], ge};
      rem <= ge ? RW'(r2 - (RW+1)'(DIVISOR)) : r2[RW-1:0];
    end
  end

  assign quotient = num;

endmodule
`default_nettype wire

// ----- hdl/cascaded_position_speed_motion_sequencer.sv -----
// Top level of the cascaded position/speed motion sequencer.
// Depends on cpsms_pkg, cpsms_item_if, cpsms_result_if and cpsms_sdiv.
//
//   channel   | kind             | carries
//   ----------+------------------+--------------------------------------------
//   item      | valid/ready sink | cmd, now_ms, position, speed, move target/limit
//   result    | valid/ready src  | duty, phase, fault, cycle, four diagnostics
//   cfg_*     | write only       | cfg_we, cfg_index, cfg_data (8 registers)
//
// One item at a time. Start, stop and ticks that do not run the controller go from
// the capture through S_ELAP and S_DEC to S_OUT; a controller tick also runs two
// 16-step shift-add multiplies (gain, feed-forward) and a 31-step divide by 100.
// Synchronous active-high reset puts the sequencer idle with default registers.
// A result held by the sink stalls the next result in S_OUT; no item is taken until it leaves.
`default_nettype none
module cascaded_position_speed_motion_sequencer #(
  parameter int POSITION_WIDTH = 24,
  parameter int TIME_WIDTH     = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  cpsms_item_if.sink                             item,
  cpsms_result_if.source                         result,
  input  logic                                   cfg_we,
  input  logic [cpsms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cpsms_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import cpsms_pkg::*;

  localparam int TGT_W  = (POSITION_WIDTH > 24) ? POSITION_WIDTH : 24;
  localparam int REM_W  = TGT_W + 1;
  localparam int MUL1_W = REM_W + 16;
  localparam int PROD_W = 31;
  localparam int MUL_STEPS = 16;

  localparam logic signed [REM_W-1:0] PE_MAX = REM_W'(32767);
  localparam logic signed [REM_W-1:0] PE_MIN = -REM_W'(32767);

  typedef enum logic [3:0] {
    S_IDLE, S_ELAP, S_DEC, S_MUL1, S_LIM, S_SERR, S_MUL2, S_INTEG, S_DIV, S_SUM,
    S_QUO, S_OUT
  } state_t;

  state_t state;
  logic [4:0] cnt;

  // configuration
  logic [22:0] outward_target;
  logic [7:0]  cycle_count;
  logic [15:0] pause_ms;
  logic [31:0] timeout_ms;
  logic [14:0] seq_limit;
  logic [15:0] position_gain;
  logic [15:0] ff_gain;
  logic [14:0] integral_limit;

  // architectural state
  logic [2:0]              phase_q;
  logic                    single_move;
  logic [1:0]              fault_q;
  logic [7:0]              cycle_q;
  logic signed [TGT_W-1:0] target_q;
  logic [14:0]             speed_limit;
  logic [TIME_WIDTH-1:0]   phase_start;
  logic signed [7:0]       duty_q;
  logic signed [15:0]      pos_err_q;
  logic signed [15:0]      speed_cmd_q;
  logic signed [15:0]      speed_err_q;
  logic signed [15:0]      integral_q;

  // captured item and working registers
  logic [1:0]              cmd_c;
  logic [TIME_WIDTH-1:0]   now_c;
  logic signed [TGT_W-1:0] pos_c;
  logic signed [15:0]      meas_c;
  logic signed [TGT_W-1:0] mtgt_c;
  logic signed [15:0]      mlim_c;
  logic [31:0]             elapsed_q;
  logic signed [REM_W-1:0] rem_q;
  logic [MUL1_W-1:0]       acc1;
  logic [MUL1_W-1:0]       mcand1;
  logic [15:0]             msh;
  logic [PROD_W-1:0]       acc2;
  logic [PROD_W-1:0]       mcand2;
  logic signed [14:0]      dclamp_q;

  // combinational helpers
  logic [TIME_WIDTH-1:0] el_diff;
  logic                  timeout_hit;
  logic                  pause_done;
  logic                  rem_pos;
  logic                  rem_neg;
  logic [REM_W-1:0]      rem_mag;
  logic signed [15:0]    pe_sat;
  logic [16:0]           mlim_mag;
  logic [14:0]           mlim_eff;
  logic [14:0]           cmd_mag;
  logic signed [16:0]    serr_wide;
  logic signed [15:0]    serr_sat;
  logic [15:0]           serr_mag;
  logic [14:0]           scmd_mag;
  logic signed [16:0]    q10_s;
  logic signed [17:0]    isum;
  logic signed [17:0]    ilim;
  logic signed [15:0]    integ_next;
  logic signed [31:0]    ff_s;
  logic signed [31:0]    dsum;
  logic signed [31:0]    serr_x10;
  logic signed [14:0]    dclamp_next;
  logic [13:0]           dmag;
  logic [26:0]           dprod;
  logic [7:0]            dq;

  sdiv_ctl_t         div10_ctl;
  sdiv_ctl_t         div100_ctl;
  logic [15:0]       q10;
  logic [PROD_W-1:0] q100;

  cpsms_sdiv #(.DW(16), .DIVISOR(10)) u_div10 (
    .clk      (clk),
    .ctl      (div10_ctl),
    .dividend (serr_mag),
    .quotient (q10)
  );

  cpsms_sdiv #(.DW(PROD_W), .DIVISOR(100)) u_div100 (
    .clk      (clk),
    .ctl      (div100_ctl),
    .dividend (acc2),
    .quotient (q100)
  );

  always_comb begin
    div10_ctl.load  = (state == S_SERR);
    div10_ctl.step  = (state == S_MUL2);
    div100_ctl.load = (state == S_INTEG);
    div100_ctl.step = (state == S_DIV);
  end

  assign item.ready = (state == S_IDLE);

  assign el_diff     = now_c - phase_start;
  assign timeout_hit = (elapsed_q > timeout_ms);
  assign pause_done  = (elapsed_q >= {16'd0, pause_ms});
  assign rem_pos     = (rem_q > 0);
  assign rem_neg     = (rem_q < 0);
  assign rem_mag     = rem_neg ? REM_W'(-rem_q) : REM_W'(rem_q);
  assign pe_sat      = (rem_q > PE_MAX) ? 16'sd32767 :
                       (rem_q < PE_MIN) ? -16'sd32767 : rem_q[15:0];

  // absolute move limit: zero becomes one, 32768 saturates
  assign mlim_mag = mlim_c[15] ? 17'(-17'(mlim_c)) : 17'(mlim_c);
  assign mlim_eff = (mlim_mag == 17'd0) ? 15'd1 :
                    (mlim_mag > 17'd32767) ? 15'd32767 : mlim_mag[14:0];

  assign cmd_mag = (acc1 > MUL1_W'(speed_limit)) ? speed_limit : acc1[14:0];

  assign serr_wide = 17'(speed_cmd_q) - 17'(meas_c);
  assign serr_sat  = (serr_wide > 17'sd32767) ? 16'sh7fff :
                     (serr_wide < -17'sd32768) ? 16'sh8000 : serr_wide[15:0];
  assign serr_mag  = serr_sat[15] ? 16'(-17'(serr_sat)) : 16'(serr_sat);
  assign scmd_mag  = speed_cmd_q[15] ? 15'(-speed_cmd_q) : speed_cmd_q[14:0];

  assign q10_s = speed_err_q[15] ? -17'($signed({1'b0, q10})) : 17'($signed({1'b0, q10}));
  assign isum  = 18'(integral_q) + 18'(q10_s);
  assign ilim  = $signed({3'b000, integral_limit});
  assign integ_next = (isum > ilim) ? 16'(ilim) : (isum < -ilim) ? 16'(-ilim) : isum[15:0];

  assign ff_s     = speed_cmd_q[15] ? -32'($signed({1'b0, q100})) : 32'($signed({1'b0, q100}));
  assign serr_x10 = (32'(speed_err_q) <<< 3) + (32'(speed_err_q) <<< 1);
  assign dsum     = ff_s + serr_x10 + 32'(integral_q);

  always_comb begin
    if (rem_pos) begin
      if (dsum < 32'(DUTY_MIN_X100))      dclamp_next = 15'(DUTY_MIN_X100);
      else if (dsum > 32'(DUTY_MAX_X100)) dclamp_next = 15'(DUTY_MAX_X100);
      else                                dclamp_next = dsum[14:0];
    end else begin
      if (dsum < -32'(DUTY_MAX_X100))     dclamp_next = -15'(DUTY_MAX_X100);
      else if (dsum > -32'(DUTY_MIN_X100)) dclamp_next = -15'(DUTY_MIN_X100);
      else                                dclamp_next = dsum[14:0];
    end
  end

  assign dmag  = dclamp_q[14] ? 14'(-dclamp_q) : dclamp_q[13:0];
  assign dprod = 27'(dmag) * 27'(RECIP100_MUL);
  assign dq    = dprod[RECIP100_SHIFT+7:RECIP100_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      outward_target <= 23'd49;
      cycle_count    <= 8'd2;
      pause_ms       <= 16'd100;
      timeout_ms     <= 32'd45000;
      seq_limit      <= 15'd300;
      position_gain  <= 16'd250;
      ff_gain        <= 16'd1667;
      integral_limit <= 15'd2500;
      phase_q        <= PH_IDLE;
      single_move    <= 1'b0;
      fault_q        <= FLT_NONE;
      cycle_q        <= '0;
      target_q       <= '0;
      speed_limit    <= 15'd300;
      phase_start    <= '0;
      duty_q         <= '0;
      pos_err_q      <= '0;
      speed_cmd_q    <= '0;
      speed_err_q    <= '0;
      integral_q     <= '0;
      result.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OUTWARD_TARGET: outward_target <= cfg_data[22:0];
          REG_CYCLE_COUNT:    cycle_count    <= cfg_data[7:0];
          REG_PAUSE_MS:       pause_ms       <= cfg_data[15:0];
          REG_TIMEOUT_MS:     timeout_ms     <= cfg_data[31:0];
          REG_SEQ_LIMIT:      seq_limit      <= cfg_data[14:0];
          REG_POSITION_GAIN:  position_gain  <= cfg_data[15:0];
          REG_FF_GAIN:        ff_gain        <= cfg_data[15:0];
          REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[14:0];
          default: ;
        endcase
      end

      // S_OUT reloads valid itself when the held result leaves
      if (result.valid && result.ready && state != S_OUT) result.valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (item.valid) begin
            cmd_c  <= item.cmd;
            now_c  <= item.now_ms;
            pos_c  <= TGT_W'(item.position);
            meas_c <= item.measured_speed;
            mtgt_c <= TGT_W'(item.move_target);
            mlim_c <= item.move_speed_limit;
            state  <= S_ELAP;
          end
        end
        S_ELAP: begin
          elapsed_q <= 32'(el_diff);
          rem_q     <= REM_W'(target_q) - REM_W'(pos_c);
          state     <= S_DEC;
        end
        S_DEC: begin
          state <= S_OUT;
          case (cmd_c)
            CMD_START_SEQ: begin
              single_move <= 1'b0;
              phase_q     <= PH_EXTEND;
              cycle_q     <= 8'd1;
              fault_q     <= FLT_NONE;
              target_q    <= TGT_W'(outward_target);
              speed_limit <= seq_limit;
              phase_start <= now_c;
              pos_err_q   <= '0;
              speed_cmd_q <= '0;
              speed_err_q <= '0;
              integral_q  <= '0;
              duty_q      <= DUTY_START;
            end
            CMD_START_MOV: begin
              single_move <= 1'b1;
              cycle_q     <= '0;
              fault_q     <= FLT_NONE;
              target_q    <= mtgt_c;
              speed_limit <= mlim_eff;
              phase_start <= now_c;
              pos_err_q   <= '0;
              speed_cmd_q <= '0;
              speed_err_q <= '0;
              integral_q  <= '0;
              duty_q      <= '0;
              phase_q     <= (mtgt_c > pos_c) ? PH_EXTEND :
                             (mtgt_c < pos_c) ? PH_RETRACT : PH_COMPLETE;
            end
            CMD_STOP: begin
              phase_q     <= PH_IDLE;
              pos_err_q   <= '0;
              speed_cmd_q <= '0;
              speed_err_q <= '0;
              integral_q  <= '0;
              duty_q      <= '0;
            end
            default: begin
              if (phase_q == PH_EXTEND || phase_q == PH_RETRACT) begin
                if (timeout_hit) begin
                  fault_q     <= (phase_q == PH_EXTEND) ? FLT_EXTEND : FLT_RETRACT;
                  phase_q     <= PH_FAULT;
                  pos_err_q   <= '0;
                  speed_cmd_q <= '0;
                  speed_err_q <= '0;
                  integral_q  <= '0;
                  duty_q      <= '0;
                end else if ((phase_q == PH_EXTEND && !rem_pos) ||
                             (phase_q == PH_RETRACT && !rem_neg)) begin
                  // target reached or passed
                  if (single_move) begin
                    phase_q <= PH_COMPLETE;
                  end else begin
                    phase_q     <= (phase_q == PH_EXTEND) ? PH_PAUSE_EXT : PH_PAUSE_RET;
                    phase_start <= now_c;
                  end
                  pos_err_q   <= '0;
                  speed_cmd_q <= '0;
                  speed_err_q <= '0;
                  integral_q  <= '0;
                  duty_q      <= '0;
                end else begin
                  pos_err_q <= pe_sat;
                  mcand1    <= MUL1_W'(rem_mag);
                  msh       <= position_gain;
                  acc1      <= '0;
                  cnt       <= '0;
                  state     <= S_MUL1;
                end
              end else if (single_move) begin
                // move mode keeps diagnostics outside the driving phases
                duty_q <= '0;
              end else begin
                pos_err_q   <= '0;
                speed_cmd_q <= '0;
                speed_err_q <= '0;
                integral_q  <= '0;
                duty_q      <= '0;
                if (phase_q == PH_PAUSE_EXT && pause_done) begin
                  phase_q     <= PH_RETRACT;
                  target_q    <= '0;
                  phase_start <= now_c;
                end else if (phase_q == PH_PAUSE_RET && pause_done) begin
                  if (cycle_q >= cycle_count) begin
                    phase_q <= PH_COMPLETE;
                  end else begin
                    cycle_q     <= cycle_q + 8'd1;
                    phase_q     <= PH_EXTEND;
                    target_q    <= TGT_W'(outward_target);
                    phase_start <= now_c;
                  end
                end
              end
            end
          endcase
        end
        S_MUL1: begin
          acc1   <= acc1 + (msh[0] ? mcand1 : '0);
          mcand1 <= mcand1 << 1;
          msh    <= msh >> 1;
          cnt    <= cnt + 5'd1;
          if (cnt == 5'(MUL_STEPS - 1)) state <= S_LIM;
        end
        S_LIM: begin
          speed_cmd_q <= rem_pos ? $signed({1'b0, cmd_mag}) : -$signed({1'b0, cmd_mag});
          state       <= S_SERR;
        end
        S_SERR: begin
          speed_err_q <= serr_sat;
          mcand2      <= PROD_W'(scmd_mag);
          msh         <= ff_gain;
          acc2        <= '0;
          cnt         <= '0;
          state       <= S_MUL2;
        end
        S_MUL2: begin
          acc2   <= acc2 + (msh[0] ? mcand2 : '0);
          mcand2 <= mcand2 << 1;
          msh    <= msh >> 1;
          cnt    <= cnt + 5'd1;
          if (cnt == 5'(MUL_STEPS - 1)) state <= S_INTEG;
        end
        S_INTEG: begin
          integral_q <= integ_next;
          cnt        <= '0;
          state      <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(PROD_W - 1)) state <= S_SUM;
        end
        S_SUM: begin
          dclamp_q <= dclamp_next;
          state    <= S_QUO;
        end
        S_QUO: begin
          duty_q <= dclamp_q[14] ? -$signed(dq) : $signed(dq);
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid               <= 1'b1;
            result.duty                <= duty_q;
            result.phase               <= phase_q;
            result.fault_code          <= fault_q;
            result.cycle_number        <= cycle_q;
            result.position_error_diag <= pos_err_q;
            result.speed_command_diag  <= speed_cmd_q;
            result.speed_error_diag    <= speed_err_q;
            result.integral_diag       <= integral_q;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- dv/cpsms_tb_if.sv -----
// Testbench-side note: channel interfaces come from the RTL (cpsms_item_if,
// cpsms_result_if); this file holds the transfer record used by the checker.
`timescale 1ns / 1ps
package cpsms_tb_pkg;
  typedef struct packed {
    logic signed [7:0]  duty;
    logic [2:0]         phase;
    logic [1:0]         fault_code;
    logic [7:0]         cycle_number;
    logic signed [15:0] pos_err;
    logic signed [15:0] speed_cmd;
    logic signed [15:0] speed_err;
    logic signed [15:0] integ;
  } status_t;
endpackage

// ----- dv/cpsms_checker.sv -----
// Status predictor and scoreboard for the motion sequencer.
// Depends on cpsms_pkg, cpsms_tb_pkg and the RTL channel interfaces.
`timescale 1ns / 1ps
module cpsms_checker
  import cpsms_pkg::*;
  import cpsms_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  cpsms_item_if                 item,
  cpsms_result_if               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    status_seen
);
  status_t expected_status[$];

  longint r_outward, r_cycles, r_pause, r_timeout, r_seq_lim, r_kp, r_kff, r_ilim;
  logic [2:0] ph;
  logic       move_mode;
  logic [1:0] flt;
  logic [7:0] cyc;
  longint tgt, lim, duty, perr, scmd, serr, integ;
  logic [31:0] t0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void halt_drive();
    duty = 0; perr = 0; scmd = 0; serr = 0; integ = 0;
  endfunction

  function automatic longint loop_step(longint err, longint meas);
    longint c, d;
    perr  = clampl(err, -32767, 32767);
    c     = clampl(err * r_kp, -lim, lim);
    scmd  = c;
    serr  = clampl(c - meas, -32768, 32767);
    integ = clampl(integ + (serr * 10) / 100, -r_ilim, r_ilim);
    d = (c * r_kff) / 100 + serr * 10 + integ;
    if (err > 0) d = clampl(d, DUTY_MIN_X100, DUTY_MAX_X100);
    else d = clampl(d, -DUTY_MAX_X100, -DUTY_MIN_X100);
    return d / 100;
  endfunction

  function automatic void predict_status(logic [1:0] c, logic [31:0] now, longint pos,
                                         longint meas, longint mt, longint ml);
    status_t s;
    longint rem;
    logic [31:0] el;
    el = now - t0;
    if (c == CMD_START_SEQ) begin
      move_mode = 0; ph = PH_EXTEND; cyc = 1; flt = FLT_NONE; tgt = r_outward;
      lim = r_seq_lim; t0 = now; halt_drive(); duty = 95;
    end else if (c == CMD_START_MOV) begin
      if (ml < 0) ml = -ml;
      if (ml == 0) ml = 1;
      if (ml > 32767) ml = 32767;
      move_mode = 1; cyc = 0; flt = FLT_NONE; tgt = mt; lim = ml; t0 = now; halt_drive();
      ph = mt > pos ? PH_EXTEND : (mt < pos ? PH_RETRACT : PH_COMPLETE);
    end else if (c == CMD_STOP) begin
      ph = PH_IDLE; halt_drive();
    end else if (move_mode) begin
      if (ph != PH_EXTEND && ph != PH_RETRACT) duty = 0;
      else if (longint'(el) > r_timeout) begin
        flt = ph == PH_EXTEND ? FLT_EXTEND : FLT_RETRACT; ph = PH_FAULT; halt_drive();
      end else begin
        rem = tgt - pos;
        if ((ph == PH_EXTEND && rem <= 0) || (ph == PH_RETRACT && rem >= 0)) begin
          ph = PH_COMPLETE; halt_drive();
        end else duty = loop_step(rem, meas);
      end
    end else begin
      case (ph)
        PH_EXTEND, PH_RETRACT: begin
          if (longint'(el) > r_timeout) begin
            flt = ph == PH_EXTEND ? FLT_EXTEND : FLT_RETRACT; ph = PH_FAULT; halt_drive();
          end else begin
            rem = ph == PH_EXTEND ? tgt - pos : pos - tgt;
            if (rem <= 0) begin
              ph = ph == PH_EXTEND ? PH_PAUSE_EXT : PH_PAUSE_RET; t0 = now; halt_drive();
            end else duty = loop_step(ph == PH_EXTEND ? rem : -rem, meas);
          end
        end
        PH_PAUSE_EXT: begin
          halt_drive();
          if (longint'(el) >= r_pause) begin ph = PH_RETRACT; tgt = 0; t0 = now; end
        end
        PH_PAUSE_RET: begin
          halt_drive();
          if (longint'(el) >= r_pause) begin
            if (cyc >= r_cycles) ph = PH_COMPLETE;
            else begin cyc = cyc + 1; ph = PH_EXTEND; tgt = r_outward; t0 = now; end
          end
        end
        default: halt_drive();
      endcase
    end
    s.duty = duty[7:0]; s.phase = ph; s.fault_code = flt; s.cycle_number = cyc;
    s.pos_err = perr[15:0]; s.speed_cmd = scmd[15:0]; s.speed_err = serr[15:0];
    s.integ = integ[15:0];
    expected_status.push_back(s);
  endfunction

  always @(posedge clk) begin
    status_t got, want;
    if (rst) begin
      r_outward = 49; r_cycles = 2; r_pause = 100; r_timeout = 45000; r_seq_lim = 300;
      r_kp = 250; r_kff = 1667; r_ilim = 2500;
      ph = PH_IDLE; move_mode = 0; flt = FLT_NONE; cyc = 0; tgt = 0; lim = 300; t0 = 0;
      halt_drive();
      expected_status.delete();
      fail_count <= 0; status_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OUTWARD_TARGET: r_outward = cfg_data[22:0];
          REG_CYCLE_COUNT:    r_cycles  = cfg_data[7:0];
          REG_PAUSE_MS:       r_pause   = cfg_data[15:0];
          REG_TIMEOUT_MS:     r_timeout = cfg_data;
          REG_SEQ_LIMIT:      r_seq_lim = cfg_data[14:0];
          REG_POSITION_GAIN:  r_kp      = cfg_data[15:0];
          REG_FF_GAIN:        r_kff     = cfg_data[15:0];
          REG_INTEGRAL_LIMIT: r_ilim    = cfg_data[14:0];
          default: ;
        endcase
      end
      // outputs first: a result cannot stem from the item taken this edge
      if (result.valid && result.ready) begin
        status_seen <= status_seen + 1;
        got = '{result.duty, result.phase, result.fault_code, result.cycle_number,
                result.position_error_diag, result.speed_command_diag,
                result.speed_error_diag, result.integral_diag};
        if (expected_status.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected status %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("ERROR: status mismatch exp %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (item.valid && item.ready)
        predict_status(item.cmd, item.now_ms, longint'(item.position),
                       longint'(item.measured_speed), longint'(item.move_target),
                       longint'(item.move_speed_limit));
    end
  end

  assign pending = expected_status.size();
endmodule

// ----- dv/cascaded_position_speed_motion_sequencer_tb.sv -----
// Top of the motion sequencer testbench: clock, reset, stimulus and verdict.
// Depends on the RTL and cpsms_checker.
`timescale 1ns / 1ps
module cascaded_position_speed_motion_sequencer_tb;
  import cpsms_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, status_seen;
  int idle_cycles, items_sent;
  logic [31:0] clock_ms;
  logic [23:0] cur_pos;
  int burst_left;

  cpsms_item_if   item ();
  cpsms_result_if result ();

  cascaded_position_speed_motion_sequencer uut (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  cpsms_checker chk (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
    .pending(pending), .status_seen(status_seen));

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver stall pattern: bursty back-pressure with quiet stretches
  int rx_mode;
  always @(negedge clk) begin
    if (rst) result.ready <= 1'b1;
    else begin
      if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: result.ready <= 1'b1;
        1: result.ready <= $urandom_range(0, 3) != 0;
        default: result.ready <= $urandom_range(0, 4) == 0;
      endcase
    end
  end

  // watchdog on transfer-free cycles
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("cascaded_position_speed_motion_sequencer verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] c, input logic [31:0] now, input logic [23:0] pos,
                           input logic [15:0] meas, input logic [23:0] mt,
                           input logic [15:0] ml);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      item.valid <= 1'b0;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    item.valid <= 1'b1; item.cmd <= c; item.now_ms <= now; item.position <= pos;
    item.measured_speed <= meas; item.move_target <= mt; item.move_speed_limit <= ml;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left == 0) item.valid <= 1'b0;
    items_sent++;
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // a tick of a plant whose position takes a random step, with noisy measured speed
  task automatic plant_tick(input int span);
    int step;
    clock_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, span) : 10;
    step = $signed($urandom_range(0, 40)) - 20;
    cur_pos = cur_pos + 24'(step);
    send_item(CMD_TICK, clock_ms, cur_pos, 16'($urandom_range(0, 4000)) - 16'd2000,
              24'($urandom), 16'($urandom));
  endtask

  task automatic random_config(input int kind);
    if (kind == 0) begin
      write_reg(REG_OUTWARD_TARGET, 1);        write_reg(REG_CYCLE_COUNT, 0);
      write_reg(REG_PAUSE_MS, 0);              write_reg(REG_TIMEOUT_MS, 0);
      write_reg(REG_SEQ_LIMIT, 1);             write_reg(REG_POSITION_GAIN, 0);
      write_reg(REG_FF_GAIN, 0);               write_reg(REG_INTEGRAL_LIMIT, 0);
    end else if (kind == 1) begin
      write_reg(REG_OUTWARD_TARGET, 23'h7fffff); write_reg(REG_CYCLE_COUNT, 255);
      write_reg(REG_PAUSE_MS, 16'hffff);         write_reg(REG_TIMEOUT_MS, 32'hffffffff);
      write_reg(REG_SEQ_LIMIT, 15'h7fff);        write_reg(REG_POSITION_GAIN, 16'hffff);
      write_reg(REG_FF_GAIN, 16'hffff);          write_reg(REG_INTEGRAL_LIMIT, 15'h7fff);
    end else begin
      write_reg(REG_OUTWARD_TARGET, $urandom_range(1, 300));
      write_reg(REG_CYCLE_COUNT, $urandom_range(0, 4));
      write_reg(REG_PAUSE_MS, $urandom_range(0, 60));
      write_reg(REG_TIMEOUT_MS, $urandom_range(0, 3) == 0 ? $urandom_range(0, 200)
                                                          : $urandom_range(500, 5000));
      write_reg(REG_SEQ_LIMIT, $urandom_range(1, 32767));
      write_reg(REG_POSITION_GAIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600));
      write_reg(REG_FF_GAIN, $urandom);
      write_reg(REG_INTEGRAL_LIMIT, $urandom_range(0, 32767));
    end
  endtask

  initial begin
    logic [1:0] c;
    int r;
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    item.valid = 0; item.cmd = CMD_TICK; item.now_ms = '0; item.position = '0;
    item.measured_speed = '0; item.move_target = '0; item.move_speed_limit = '0;
    items_sent = 0; burst_left = 0; clock_ms = 0; cur_pos = 0;
    repeat (5) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // directed: default registers, special cases and field extremes
    send_item(CMD_TICK, 0, 0, 0, 0, 0);
    send_item(CMD_START_SEQ, 100, 0, 0, 0, 0);
    send_item(CMD_TICK, 110, 10, 16'sh7fff, 0, 0);
    send_item(CMD_TICK, 120, 24'sh800000, 16'sh8000, 0, 0);
    send_item(CMD_TICK, 130, 60, 0, 0, 0);
    send_item(CMD_TICK, 150, 60, 0, 0, 0);
    send_item(CMD_TICK, 240, 60, 0, 0, 0);
    send_item(CMD_TICK, 250, 24'sh7fffff, 16'sh8000, 0, 0);
    send_item(CMD_TICK, 260, -5, 0, 0, 0);
    send_item(CMD_TICK, 400, -5, 0, 0, 0);
    send_item(CMD_TICK, 99000, 0, 0, 0, 0);
    send_item(CMD_START_MOV, 1000, 0, 0, 24'sh7fffff, 16'sh8000);
    send_item(CMD_TICK, 1010, 0, 16'sh7fff, 0, 0);
    send_item(CMD_START_MOV, 2000, 0, 0, 24'sh800000, 0);
    send_item(CMD_TICK, 2010, 0, 0, 0, 0);
    send_item(CMD_TICK, 60000, 0, 0, 0, 0);
    send_item(CMD_START_MOV, 3000, 5, 0, 5, -7);
    send_item(CMD_START_MOV, 32'hffff_fff0, 0, 0, 100, 300);
    send_item(CMD_TICK, 32'h0000_0010, 200, 0, 0, 0);
    send_item(CMD_START_MOV, 4000, 0, 0, -100, 1);
    send_item(CMD_STOP, 4010, 0, 0, 0, 0);
    send_item(CMD_TICK, 4020, 0, 0, 0, 0);
    drain();
    random_config(0);
    send_item(CMD_START_SEQ, 0, 0, 0, 0, 0);
    send_item(CMD_TICK, 1, 0, 0, 0, 0);
    send_item(CMD_START_MOV, 5, 0, 0, 3, 5);
    send_item(CMD_TICK, 5, 0, 0, 0, 0);
    drain();
    random_config(1);

    // random phases: mostly plausible motion runs, some noise
    for (int ph_i = 0; ph_i < 12; ph_i++) begin
      for (int k = 0; k < 170; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          cur_pos = 24'($urandom_range(0, 40)) - 24'd20;
          send_item(CMD_START_SEQ, clock_ms, cur_pos, 0, 0, 0);
        end else if (r < 6) begin
          send_item(CMD_START_MOV, clock_ms, cur_pos, 0,
                    $urandom_range(0, 5) == 0 ? 24'($urandom) :
                      cur_pos + 24'($urandom_range(0, 400)) - 24'd200,
                    16'($urandom));
        end else if (r < 8) begin
          send_item(CMD_STOP, clock_ms, cur_pos, 16'($urandom), 24'($urandom), 16'($urandom));
        end else if (r < 11) begin
          c = 2'($urandom);
          clock_ms = $urandom;
          cur_pos = 24'($urandom);
          send_item(c, clock_ms, cur_pos, 16'($urandom), 24'($urandom), 16'($urandom));
        end else plant_tick(ph_i % 3 == 0 ? 6000 : 100);
      end
      drain();
      random_config(ph_i == 11 ? 1 : (ph_i == 5 ? 0 : 2));
    end

    drain();
    $display("Run covered %0d items and %0d status transfers over 14 register settings.",
             items_sent, status_seen);
    if (fail_count == 0)
      $display("cascaded_position_speed_motion_sequencer verification clean");
    else
      $display("cascaded_position_speed_motion_sequencer verification failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/cpsms_pkg.sv
hdl/cpsms_item_if.sv
hdl/cpsms_result_if.sv
hdl/cpsms_sdiv.sv
hdl/cascaded_position_speed_motion_sequencer.sv
dv/cpsms_tb_if.sv
dv/cpsms_checker.sv
dv/cascaded_position_speed_motion_sequencer_tb.sv
